FILE: hw/rtl/vvhs_pkg.sv
// Shared types and constants for the velocity Verlet half-step block.
// Used by vvhs_lane and velocity_verlet_half_step_top; depends on nothing.
package vvhs_pkg;

   // Quotient bits resolved by the pipelined divider. Larger quotients
   // saturate the velocity anyway.
   localparam int unsigned DIV_STEPS  = 33;
   // Lane stages: multiply, add, divider setup, divider steps, velocity,
   // magnitude, drift multiply, position.
   localparam int unsigned LANE_DEPTH = DIV_STEPS + 7;
   // Input register and operand preparation come ahead of the lanes.
   localparam int unsigned PIPE_DEPTH = LANE_DEPTH + 2;

   typedef enum logic [1:0] {
      MODE_ATOM_INIT  = 2'd0,
      MODE_ATOM_FINAL = 2'd1,
      MODE_EXT_INIT   = 2'd2,
      MODE_EXT_FINAL  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_POS_STEP   = 3'd0,
      CSR_KICK_STEP  = 3'd1,
      CSR_TARGET_POT = 3'd2,
      CSR_NE_MASS    = 3'd3,
      CSR_EXT_ENABLE = 3'd4
   } csr_index_type;

   // Operands of one component as it enters a lane.
   typedef struct packed {
      logic [32:0]        mag;     // force magnitude
      logic               neg;     // force sign
      logic [31:0]        mass;    // never zero
      logic signed [31:0] vel;
      logic signed [31:0] pos;
      logic               active;  // apply the velocity kick
      logic               drift;   // apply the position drift
   } lane_in_type;

   typedef struct packed {
      logic signed [31:0] pos;
      logic signed [31:0] vel;
   } lane_out_type;

endpackage

FILE: hw/rtl/velocity_verlet_half_step_top.sv
// Top level of the velocity Verlet half-step block: stream ports, control
// registers, operand preparation, three vvhs_lane instances, output skid.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  tdata 320 bits, tuser 3 bits
//   rsp      out        rsp_tvalid/rsp_tready  tdata 192 bits
//   csr      in         csr_we                 csr_index 3 bits, csr_wdata 32 bits
//
// One transaction is accepted per cycle while req_tready is high; results pass
// through the input register, preparation, 40 lane stages and output register;
// the depth is set by the one-bit-per-stage divider (force times kick over mass).
// Reset is synchronous; it clears the valid bits and control registers only, but
// sets NE_MASS to 1048576. req_tready stays low while reset is high.
// A result reaching a stalled output goes into a skid register; req_tready drops
// only while it is full, and the whole pipeline then holds without loss.
module velocity_verlet_half_step_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, force_x, force_y, force_z, atom_mass
   input  logic [319:0] req_tdata,
   // mode, in_group
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
   output logic [191:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int unsigned PD = vvhs_pkg::PIPE_DEPTH;

   // Control registers.
   logic [31:0] pos_step_ff;
   logic [31:0] kick_step_ff;
   logic [31:0] target_pot_ff;
   logic [31:0] ne_mass_ff;
   logic        ext_enable_ff;

   logic          en;
   logic [PD-1:0] vld_ff;

   // Input register.
   logic [1:0]         s1_mode_ff;
   logic               s1_grp_ff;
   logic signed [31:0] s1_pos_ff   [0:2];
   logic signed [31:0] s1_vel_ff   [0:2];
   logic signed [31:0] s1_force_ff [0:2];
   logic [31:0]        s1_mass_ff;

   // Prepared lane operands.
   vvhs_pkg::lane_in_type  s2_lane_ff [0:2];
   vvhs_pkg::lane_in_type  s2_lane_in [0:2];
   vvhs_pkg::lane_out_type lane_out   [0:2];

   // Output side.
   logic         take;
   logic [191:0] pipe_data;
   logic         out_valid_ff;
   logic         out_valid_in;
   logic [191:0] out_data_ff;
   logic [191:0] out_data_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   logic [191:0] skid_data_ff;
   logic [191:0] skid_data_in;

   assign en         = !skid_valid_ff;
   assign req_tready = en && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_step_ff   <= 32'd0;
         kick_step_ff  <= 32'd0;
         target_pot_ff <= 32'd0;
         ne_mass_ff    <= 32'd1048576;
         ext_enable_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            vvhs_pkg::CSR_POS_STEP:   pos_step_ff   <= csr_wdata;
            vvhs_pkg::CSR_KICK_STEP:  kick_step_ff  <= csr_wdata;
            vvhs_pkg::CSR_TARGET_POT: target_pot_ff <= csr_wdata;
            vvhs_pkg::CSR_NE_MASS:    ne_mass_ff    <= csr_wdata;
            vvhs_pkg::CSR_EXT_ENABLE: ext_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PD-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_mode_ff <= req_tuser[1:0];
         s1_grp_ff  <= req_tuser[2];
         for (int k = 0; k < 3; k++) begin
            s1_pos_ff[k]   <= req_tdata[32*k +: 32];
            s1_vel_ff[k]   <= req_tdata[96 + 32*k +: 32];
            s1_force_ff[k] <= req_tdata[192 + 32*k +: 32];
         end
         s1_mass_ff <= req_tdata[319:288];
         for (int k = 0; k < 3; k++) begin
            s2_lane_ff[k] <= s2_lane_in[k];
         end
      end
   end

   // In the extended modes only the x lane works, on target minus dE/dN.
   // Both differences are formed side by side so the magnitude needs no negate.
   always_comb begin
      logic        atom;
      logic        init;
      logic        ext_on;
      logic [32:0] ext_diff;
      logic [32:0] ext_rdiff;
      logic [31:0] mass;
      atom = (s1_mode_ff == vvhs_pkg::MODE_ATOM_INIT) ||
             (s1_mode_ff == vvhs_pkg::MODE_ATOM_FINAL);
      init = (s1_mode_ff == vvhs_pkg::MODE_ATOM_INIT) ||
             (s1_mode_ff == vvhs_pkg::MODE_EXT_INIT);
      ext_on = !atom && ext_enable_ff;
      ext_diff  = {target_pot_ff[31], target_pot_ff} - {s1_force_ff[0][31], s1_force_ff[0]};
      ext_rdiff = {s1_force_ff[0][31], s1_force_ff[0]} - {target_pot_ff[31], target_pot_ff};
      mass = atom ? s1_mass_ff : ne_mass_ff;
      if (mass == 32'd0) begin
         mass = 32'd1;
      end
      for (int k = 0; k < 3; k++) begin
         s2_lane_in[k].mass   = mass;
         s2_lane_in[k].vel    = s1_vel_ff[k];
         s2_lane_in[k].pos    = s1_pos_ff[k];
         s2_lane_in[k].active = atom ? s1_grp_ff : ((k == 0) && ext_on);
         s2_lane_in[k].drift  = init && (atom ? s1_grp_ff : ((k == 0) && ext_on));
         if (!atom && (k == 0)) begin
            s2_lane_in[k].neg = ext_diff[32];
            s2_lane_in[k].mag = ext_diff[32] ? ext_rdiff : ext_diff;
         end else begin
            s2_lane_in[k].neg = s1_force_ff[k][31];
            s2_lane_in[k].mag = s1_force_ff[k][31] ?
                                33'(33'd0 - {s1_force_ff[k][31], s1_force_ff[k]}) :
                                {1'b0, s1_force_ff[k]};
         end
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      vvhs_lane u_lane (
         .clock     (clock),
         .en        (en),
         .kick_step (kick_step_ff),
         .pos_step  (pos_step_ff),
         .lane_i    (s2_lane_ff[k]),
         .lane_o    (lane_out[k])
      );
   end

   assign take      = en && vld_ff[PD-1];
   assign pipe_data = {lane_out[2].vel, lane_out[1].vel, lane_out[0].vel,
                       lane_out[2].pos, lane_out[1].pos, lane_out[0].pos};

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = take;
            out_data_in  = pipe_data;
         end
      end else if (take) begin
         skid_valid_in = 1'b1;
         skid_data_in  = pipe_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

FILE: hw/rtl/vvhs_lane.sv
// One vector component of the half step: kick, saturation and drift.
// Depends on vvhs_pkg for the lane operand types and the divider depth.
module vvhs_lane (
   input  logic                  clock,
   input  logic                  en,
   input  logic [31:0]           kick_step,
   input  logic [31:0]           pos_step,
   input  vvhs_pkg::lane_in_type lane_i,
   output vvhs_pkg::lane_out_type lane_o
);

   localparam int unsigned NS = vvhs_pkg::DIV_STEPS;

   localparam logic signed [34:0] V_HI = 35'sd2147483647;
   localparam logic signed [34:0] V_LO = -35'sd2147483648;
   localparam logic signed [41:0] P_HI = 42'sd2147483647;
   localparam logic signed [41:0] P_LO = -42'sd2147483648;

   typedef struct packed {
      logic [31:0]        mass;
      logic signed [31:0] vel;
      logic signed [31:0] pos;
      logic               neg;
      logic               active;
      logic               drift;
   } side_type;

   // Multiply stage.
   logic [63:0] m_prod_ff;
   logic [63:0] m_prod_in;
   logic        m_top_ff;
   side_type    m_side_ff;
   side_type    lane_side;

   // Add stage: full product shifted right by eight.
   logic [56:0] a_div_ff;
   logic [64:0] a_sum_in;
   side_type    a_side_ff;

   // Divider setup and steps; index 0 is the setup stage.
   logic [31:0]   rem_ff  [0:NS];
   logic [NS-1:0] word_ff [0:NS];
   logic          ovf_ff  [0:NS];
   side_type      side_ff [0:NS];
   logic [31:0]   rem_in  [0:NS-1];
   logic [NS-1:0] word_in [0:NS-1];
   logic [23:0]   init_hi;

   // Velocity, magnitude, drift multiply and position stages.
   logic signed [31:0] v_vel_ff;
   logic signed [31:0] v_vel_in;
   logic signed [31:0] v_pos_ff;
   logic               v_drift_ff;
   logic [31:0]        b_mag_ff;
   logic               b_neg_ff;
   logic signed [31:0] b_vel_ff;
   logic signed [31:0] b_pos_ff;
   logic               b_drift_ff;
   logic [63:0]        c_prod_ff;
   logic               c_neg_ff;
   logic signed [31:0] c_vel_ff;
   logic signed [31:0] c_pos_ff;
   logic               c_drift_ff;
   logic signed [31:0] out_pos_ff;
   logic signed [31:0] out_pos_in;
   logic signed [31:0] out_vel_ff;

   always_comb begin
      lane_side.mass   = lane_i.mass;
      lane_side.vel    = lane_i.vel;
      lane_side.pos    = lane_i.pos;
      lane_side.neg    = lane_i.neg;
      lane_side.active = lane_i.active;
      lane_side.drift  = lane_i.drift;
      m_prod_in = 64'(lane_i.mag[31:0]) * 64'(kick_step);
      a_sum_in  = {1'b0, m_prod_ff} + (m_top_ff ? {1'b0, kick_step, 32'd0} : 65'd0);
   end

   assign init_hi = a_div_ff[56:NS];

   // One restoring step per stage; remainder < mass while ovf is clear.
   always_comb begin
      for (int j = 0; j < NS; j++) begin
         logic [32:0] trial;
         logic        ge;
         trial      = {rem_ff[j], word_ff[j][NS-1]};
         ge         = trial >= {1'b0, side_ff[j].mass};
         rem_in[j]  = ge ? 32'(trial - {1'b0, side_ff[j].mass}) : trial[31:0];
         word_in[j] = {word_ff[j][NS-2:0], ge};
      end
   end

   always_comb begin
      logic signed [34:0] vsum;
      logic signed [34:0] qext;
      qext = $signed({2'b00, word_ff[NS]});
      vsum = side_ff[NS].neg ? (35'(side_ff[NS].vel) - qext) : (35'(side_ff[NS].vel) + qext);
      if (!side_ff[NS].active) begin
         v_vel_in = side_ff[NS].vel;
      end else if (ovf_ff[NS]) begin
         v_vel_in = side_ff[NS].neg ? V_LO[31:0] : V_HI[31:0];
      end else if (vsum > V_HI) begin
         v_vel_in = V_HI[31:0];
      end else if (vsum < V_LO) begin
         v_vel_in = V_LO[31:0];
      end else begin
         v_vel_in = vsum[31:0];
      end
   end

   always_comb begin
      logic signed [41:0] psum;
      logic signed [41:0] dext;
      dext = $signed({2'b00, c_prod_ff[63:24]});
      psum = c_neg_ff ? (42'(c_pos_ff) - dext) : (42'(c_pos_ff) + dext);
      if (!c_drift_ff) begin
         out_pos_in = c_pos_ff;
      end else if (psum > P_HI) begin
         out_pos_in = P_HI[31:0];
      end else if (psum < P_LO) begin
         out_pos_in = P_LO[31:0];
      end else begin
         out_pos_in = psum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_prod_ff <= m_prod_in;
         m_top_ff  <= lane_i.mag[32];
         m_side_ff <= lane_side;

         a_div_ff  <= a_sum_in[64:8];
         a_side_ff <= m_side_ff;

         rem_ff[0]  <= {8'd0, init_hi};
         word_ff[0] <= a_div_ff[NS-1:0];
         ovf_ff[0]  <= {8'd0, init_hi} >= a_side_ff.mass;
         side_ff[0] <= a_side_ff;
         for (int j = 0; j < NS; j++) begin
            rem_ff[j+1]  <= rem_in[j];
            word_ff[j+1] <= word_in[j];
            ovf_ff[j+1]  <= ovf_ff[j];
            side_ff[j+1] <= side_ff[j];
         end

         v_vel_ff   <= v_vel_in;
         v_pos_ff   <= side_ff[NS].pos;
         v_drift_ff <= side_ff[NS].drift;

         b_mag_ff   <= v_vel_ff[31] ? 32'(32'd0 - v_vel_ff) : v_vel_ff;
         b_neg_ff   <= v_vel_ff[31];
         b_vel_ff   <= v_vel_ff;
         b_pos_ff   <= v_pos_ff;
         b_drift_ff <= v_drift_ff;

         c_prod_ff  <= 64'(b_mag_ff) * 64'(pos_step);
         c_neg_ff   <= b_neg_ff;
         c_vel_ff   <= b_vel_ff;
         c_pos_ff   <= b_pos_ff;
         c_drift_ff <= b_drift_ff;

         out_pos_ff <= out_pos_in;
         out_vel_ff <= c_vel_ff;
      end
   end

   assign lane_o.pos = out_pos_ff;
   assign lane_o.vel = out_vel_ff;

endmodule

FILE: hw/rtl/vvhs_checker.sv
// Port-level checks for velocity_verlet_half_step_top, attached by bind.
// Depends only on the top level's port names.
module vvhs_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [191:0] rsp_tdata
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result payload changed while stalled");

   // The input side closes only when the skid register is full, which needs
   // a result waiting at the output.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input closed with no result waiting");

   // Taking the waiting result drains the skid register at once.
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      !req_tready && rsp_tready |=> req_tready)
      else $error("input stayed closed after the result was taken");

   // No result is offered right after reset.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind velocity_verlet_half_step_top vvhs_checker u_vvhs_checker (.*);
